// ----- design/circular_deque_unit_macros.svh -----
// Assertion macros shared by the circular deque modules.
// Expects clk and arst_n to be visible in the module that uses them.
`ifndef CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define CIRCULAR_DEQUE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/cdq_pkg.sv -----
// Types, codes and constants of the circular deque unit.
// No dependencies; imported by every module of the block.
package cdq_pkg;

	localparam int unsigned SLOTS_DEF  = 16;
	localparam int unsigned CAP_W      = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd15;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned PDATA_W    = 32;
	localparam logic REG_CAPACITY      = 1'b0;
	localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

	localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FUNC_PUSH_REAR  = 3'd1;
	localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [2:0] FUNC_POP_REAR   = 3'd3;

	typedef struct packed {
		logic [2:0]               func;
		logic signed [DATA_W-1:0] data;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic                     is_empty;
		logic                     is_full;
		logic                     ignored;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic op_en;
		logic rd_en;
	} dp_cmd_t;

	typedef struct packed {
		logic                 wr_en;
		logic [CAP_W-1:0]     capacity;
	} cfg_cmd_t;

endpackage

// ----- design/circular_deque_unit.sv -----
// Top level of the circular deque unit: APB register decode and module wiring.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
//
// Usage: each request transfer (req_valid, req_stall, req_data) carries one
// operation: push front, push rear, pop front, pop rear or query. Every request
// yields exactly one response transfer (rsp_valid, rsp_stall, rsp_data) with
// the front and rear words after the operation (-1 when empty), the empty and
// full flags, and a flag set when a push met a full ring or a pop an empty one.
// A taken request updates the ring; both ends of the ring store are then read
// into registers, and the response follows, so no new request is taken while
// one is in flight. The next request is taken in the same cycle its
// predecessor's response transfers. While the receiver stalls, the response
// holds and req_stall stays high. Reset empties the deque and sets the
// capacity to fifteen; store contents are not cleared, and the block accepts
// requests right after reset. Writing the capacity register at addresses zero
// to three also empties the deque; a capacity of zero acts as one.
//
module circular_deque_unit import cdq_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	dp_cmd_t          cmd;
	cfg_cmd_t         cfg;
	logic [CAP_W-1:0] capacity;
	logic             reg_sel;

	assign pready       = 1'b1;
	assign reg_sel      = paddr[PADDR_W-1];
	assign cfg.wr_en    = psel && penable && pwrite && pready && (reg_sel == REG_CAPACITY);
	assign cfg.capacity = pwdata[CAP_W-1:0];
	assign prdata       = (reg_sel == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	cdq_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.req_data (req_data),
		.rsp_data (rsp_data),
		.capacity (capacity)
	);

endmodule

// ----- design/cdq_ctrl.sv -----
// Transfer sequencer of the circular deque unit.
// Depends on cdq_pkg and circular_deque_unit_macros.svh.
`include "circular_deque_unit_macros.svh"

module cdq_ctrl import cdq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				rsp_valid = 1'b1;
				req_stall = rsp_stall;
				if (!rsp_stall && req_valid) begin
					state_nxt = ST_READ;
				end else if (!rsp_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		cmd.op_en = req_valid && !req_stall;
	end

	`CDQ_ASSERT_NOW(a_hold_input, rsp_valid && rsp_stall, req_stall, "Input taken while result held")
	`CDQ_ASSERT_NEXT(a_op_reads, cmd.op_en, cmd.rd_en, "Accepted transfer not followed by a read")

endmodule

// ----- design/cdq_datapath.sv -----
// Ring store, head and tail indices and result registers of the deque.
// Depends on cdq_pkg and circular_deque_unit_macros.svh.
`include "circular_deque_unit_macros.svh"

module cdq_datapath import cdq_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  cfg_cmd_t         cfg,
	input  req_t             req_data,
	output rsp_t             rsp_data,
	output logic [CAP_W-1:0] capacity
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] i,
		input logic [IW-1:0] last);
		step_fwd = (i == last) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] step_back(input logic [IW-1:0] i,
		input logic [IW-1:0] last);
		step_back = (i == '0) ? last : i - 1'b1;
	endfunction

	function automatic logic [IW-1:0] last_of(input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] cap_eff;
		cap_eff = (cap == '0) ? CAP_W'(1) : cap;
		if (32'(cap_eff) > 32'(SLOTS - 1)) begin
			last_of = IW'(SLOTS - 1);
		end else begin
			last_of = IW'(cap_eff);
		end
	endfunction

	logic signed [DATA_W-1:0] ring_mem [SLOTS];
	logic signed [DATA_W-1:0] front_rd_q, rear_rd_q;
	logic [IW-1:0]            head_q, tail_q, last_q;
	logic [CAP_W-1:0]         cap_q;
	logic                     ign_q;

	logic [IW-1:0] head_nxt, tail_nxt, wr_addr;
	logic          wr_en, ign_nxt, empty_now, full_now;

	assign empty_now = (head_q == tail_q);
	assign full_now  = (head_q == step_fwd(tail_q, last_q));

	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		wr_addr  = tail_q;
		wr_en    = 1'b0;
		ign_nxt  = 1'b0;
		case (req_data.func)
			FUNC_PUSH_FRONT: begin
				if (full_now) begin
					ign_nxt = 1'b1;
				end else begin
					head_nxt = step_back(head_q, last_q);
					wr_addr  = head_nxt;
					wr_en    = 1'b1;
				end
			end
			FUNC_PUSH_REAR: begin
				if (full_now) begin
					ign_nxt = 1'b1;
				end else begin
					tail_nxt = step_fwd(tail_q, last_q);
					wr_en    = 1'b1;
				end
			end
			FUNC_POP_FRONT: begin
				if (empty_now) begin
					ign_nxt = 1'b1;
				end else begin
					head_nxt = step_fwd(head_q, last_q);
				end
			end
			FUNC_POP_REAR: begin
				if (empty_now) begin
					ign_nxt = 1'b1;
				end else begin
					tail_nxt = step_back(tail_q, last_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cap_q  <= CAP_RESET;
			last_q <= last_of(CAP_RESET);
			ign_q  <= 1'b0;
		end else if (cfg.wr_en) begin
			head_q <= '0;
			tail_q <= '0;
			cap_q  <= cfg.capacity;
			last_q <= last_of(cfg.capacity);
		end else if (cmd.op_en) begin
			head_q <= head_nxt;
			tail_q <= tail_nxt;
			ign_q  <= ign_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_en && wr_en) begin
			ring_mem[wr_addr] <= req_data.data;
		end
		if (cmd.rd_en) begin
			front_rd_q <= ring_mem[head_q];
			rear_rd_q  <= ring_mem[step_back(tail_q, last_q)];
		end
	end

	assign rsp_data.front_value = empty_now ? EMPTY_WORD : front_rd_q;
	assign rsp_data.rear_value  = empty_now ? EMPTY_WORD : rear_rd_q;
	assign rsp_data.is_empty    = empty_now;
	assign rsp_data.is_full     = full_now;
	assign rsp_data.ignored     = ign_q;
	assign capacity             = cap_q;

	`CDQ_ASSERT_NOW(a_head_range, 1'b1, head_q <= last_q, "Head index beyond ring")
	`CDQ_ASSERT_NOW(a_tail_range, 1'b1, tail_q <= last_q, "Tail index beyond ring")
	`CDQ_ASSERT_NOW(a_empty_full, empty_now, !full_now, "Ring reports empty and full")

endmodule
